[design/hrsp_pkg.sv]
package hrsp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               payload_valid;
    logic               done_res;
    logic [1:0]         status;
    logic signed [63:0] ret_value;
  } out_item_t;

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [2:0] VS_START  = 3'd0;
  localparam logic [2:0] VS_SIGN   = 3'd1;
  localparam logic [2:0] VS_DIGITS = 3'd2;
  localparam logic [2:0] VS_LF     = 3'd3;
  localparam logic [2:0] VS_ERR    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NOT200  = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  localparam logic [4:0] HDR_MATCHED  = 5'd16;
  localparam logic [4:0] HDR_MISMATCH = 5'd31;
  localparam logic [2:0] CODE_LEN     = 3'd3;
  localparam logic [2:0] CODE_BAD     = 3'd4;
  localparam logic [1:0] SPACE_MAX    = 2'd2;
  localparam logic [31:0] VALUE_BYTES = 32'd8;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  space_count;
    logic [2:0]  code_match_pos;
    logic [4:0]  header_match_pos;
    logic        line_empty;
    logic        after_cr;
    logic [31:0] length_acc;
    logic        length_known;
    logic        length_negative;
    logic [31:0] body_count;
    logic [63:0] value_shift;
    logic        verdict_given;
    logic        payload_fits;
    logic [2:0]  value_state;
  } parse_state_t;

  localparam parse_state_t PARSE_INIT = '{
    phase:            PH_STATUS,
    space_count:      2'd0,
    code_match_pos:   3'd0,
    header_match_pos: 5'd0,
    line_empty:       1'b1,
    after_cr:         1'b0,
    length_acc:       32'd0,
    length_known:     1'b0,
    length_negative:  1'b0,
    body_count:       32'd0,
    value_shift:      64'd0,
    verdict_given:    1'b0,
    payload_fits:     1'b0,
    value_state:      VS_START
  };

  function automatic logic [7:0] code_char(input logic [1:0] pos);
    case (pos)
      2'd0:    code_char = "2";
      2'd1:    code_char = "0";
      2'd2:    code_char = "0";
      default: code_char = CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] pos);
    case (pos)
      4'd0:    cl_char = "c";
      4'd1:    cl_char = "o";
      4'd2:    cl_char = "n";
      4'd3:    cl_char = "t";
      4'd4:    cl_char = "e";
      4'd5:    cl_char = "n";
      4'd6:    cl_char = "t";
      4'd7:    cl_char = "-";
      4'd8:    cl_char = "l";
      4'd9:    cl_char = "e";
      4'd10:   cl_char = "n";
      4'd11:   cl_char = "g";
      4'd12:   cl_char = "t";
      4'd13:   cl_char = "h";
      4'd14:   cl_char = ":";
      4'd15:   cl_char = " ";
      default: cl_char = CH_NUL;
    endcase
  endfunction

endpackage

[design/http_response_stream_parser.sv]
// An accepted byte is held in the input register; its result is registered in the
// output register, from which it can be taken.
// Throughput: one received byte per cycle unless a stalled output holds it; the parse
// state lives in one register set, updated by the step logic between the two registers.
// Reset (rst, synchronous) clears the parse state, empties both registers and sets
// max_payload to 4096. Configuration writes are taken in every cycle.
module http_response_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrsp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import hrsp_pkg::*;

  logic         in_q_valid;
  in_item_t     in_q;
  parse_state_t st;
  parse_state_t st_next;
  out_item_t    res;
  logic         has_res;
  logic [15:0]  max_payload;
  logic         advance;

  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && out_valid && out_stall;
  assign cfg_ready = 1'b1;

  hrsp_parse u_parse (
    .st          (st),
    .item        (in_q),
    .max_payload (max_payload),
    .st_next     (st_next),
    .res         (res),
    .has_res     (has_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_INIT;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

[design/hrsp_parse.sv]
module hrsp_parse (
  input  hrsp_pkg::parse_state_t st,
  input  hrsp_pkg::in_item_t     item,
  input  logic [15:0]            max_payload,
  output hrsp_pkg::parse_state_t st_next,
  output hrsp_pkg::out_item_t    res,
  output logic                   has_res
);
  import hrsp_pkg::*;

  parse_state_t s;
  logic [7:0]  b;
  logic [7:0]  lc;
  logic        dig;
  logic [35:0] acc_times10;
  logic [35:0] limit;
  logic        ovf;
  logic [31:0] acc_minus8;
  logic        vd;
  logic [1:0]  vst;
  logic [63:0] vval;
  logic        pv;
  logic [7:0]  pb;

  assign b   = item.rx_byte;
  assign dig = (b >= CH_0) && (b <= CH_9);
  assign lc  = ((b >= CH_UA) && (b <= CH_UZ)) ? b + CASE_OFS : b;

  // Accumulator times ten plus the new digit, checked against the signed 32-bit range.
  assign acc_times10 = {1'b0, st.length_acc, 3'b000} + {3'b000, st.length_acc, 1'b0}
                     + {32'd0, b[3:0]};
  assign limit       = st.length_negative ? 36'h080000000 : 36'h07FFFFFFF;
  assign ovf         = acc_times10 > limit;
  assign acc_minus8  = st.length_acc - VALUE_BYTES;

  always_comb begin
    s    = st;
    vd   = 1'b0;
    vst  = ST_OK;
    vval = 64'd0;
    pv   = 1'b0;
    pb   = 8'd0;
    if (st.phase != PH_DONE) begin
      s.after_cr = 1'b0;
      if (!(st.after_cr && b == CH_LF)) begin
        case (st.phase)
          PH_STATUS: begin
            if (b == CH_NUL) begin
              vd  = 1'b1;
              vst = ST_BAD;
            end else if (b == CH_CR) begin
              if (st.space_count == 2'd0) begin
                vd  = 1'b1;
                vst = ST_BAD;
              end else if (st.code_match_pos == CODE_LEN) begin
                s.phase            = PH_HEADER;
                s.after_cr         = 1'b1;
                s.line_empty       = 1'b1;
                s.header_match_pos = 5'd0;
              end else begin
                vd  = 1'b1;
                vst = ST_NOT200;
              end
            end else if (b == CH_SP) begin
              if (st.space_count < SPACE_MAX) begin
                s.space_count = st.space_count + 2'd1;
              end
            end else if (st.space_count == 2'd1) begin
              if (st.code_match_pos < CODE_LEN &&
                  b == code_char(st.code_match_pos[1:0])) begin
                s.code_match_pos = st.code_match_pos + 3'd1;
              end else begin
                s.code_match_pos = CODE_BAD;
              end
            end
          end
          PH_HEADER: begin
            if (b == CH_NUL) begin
              vd  = 1'b1;
              vst = ST_BAD;
            end else if (b == CH_CR) begin
              if (st.line_empty) begin
                if (!st.length_known || st.length_negative ||
                    st.length_acc < VALUE_BYTES) begin
                  vd  = 1'b1;
                  vst = ST_BAD;
                end else begin
                  s.phase        = PH_BODY;
                  s.body_count   = 32'd0;
                  s.value_shift  = 64'd0;
                  s.payload_fits = acc_minus8 <= {16'd0, max_payload};
                  s.after_cr     = 1'b1;
                end
              end else if (st.header_match_pos == HDR_MATCHED &&
                           !(st.value_state == VS_DIGITS || st.value_state == VS_LF)) begin
                vd  = 1'b1;
                vst = ST_BAD;
              end else begin
                if (st.header_match_pos == HDR_MATCHED) begin
                  s.length_known = 1'b1;
                end
                s.line_empty       = 1'b1;
                s.header_match_pos = 5'd0;
                s.after_cr         = 1'b1;
              end
            end else begin
              s.line_empty = 1'b0;
              if (st.header_match_pos < HDR_MATCHED) begin
                if (lc == cl_char(st.header_match_pos[3:0])) begin
                  s.header_match_pos = st.header_match_pos + 5'd1;
                  if (s.header_match_pos == HDR_MATCHED) begin
                    s.length_acc      = 32'd0;
                    s.length_negative = 1'b0;
                    s.value_state     = VS_START;
                  end
                end else begin
                  s.header_match_pos = HDR_MISMATCH;
                end
              end else if (st.header_match_pos == HDR_MATCHED) begin
                case (st.value_state)
                  VS_START, VS_SIGN, VS_DIGITS: begin
                    if (dig) begin
                      s.value_state = ovf ? VS_ERR : VS_DIGITS;
                      if (!ovf) begin
                        s.length_acc = acc_times10[31:0];
                      end
                    end else if (st.value_state == VS_START && b == CH_PLUS) begin
                      s.value_state = VS_SIGN;
                    end else if (st.value_state == VS_START && b == CH_MINUS) begin
                      s.length_negative = 1'b1;
                      s.value_state     = VS_SIGN;
                    end else if (st.value_state == VS_DIGITS && b == CH_LF) begin
                      s.value_state = VS_LF;
                    end else begin
                      s.value_state = VS_ERR;
                    end
                  end
                  default: begin
                    s.value_state = VS_ERR;
                  end
                endcase
              end
            end
          end
          default: begin
            if (st.body_count < VALUE_BYTES) begin
              s.value_shift[{st.body_count[2:0], 3'b000} +: 8] =
                st.value_shift[{st.body_count[2:0], 3'b000} +: 8] | b;
            end else if (st.payload_fits) begin
              pv = 1'b1;
              pb = b;
            end
            s.body_count = st.body_count + 32'd1;
            if (s.body_count >= st.length_acc) begin
              vd = 1'b1;
              if (st.payload_fits) begin
                vst  = ST_OK;
                vval = s.value_shift;
              end else begin
                vst = ST_NOSPACE;
              end
            end
          end
        endcase
      end
    end
    if (vd) begin
      s.verdict_given = 1'b1;
      s.phase         = PH_DONE;
    end
    if (item.rx_last) begin
      if (!s.verdict_given) begin
        vd   = 1'b1;
        vst  = ST_BAD;
        vval = 64'd0;
      end
      s = PARSE_INIT;
    end
  end

  assign st_next           = s;
  assign has_res           = pv || vd;
  assign res.payload_byte  = pb;
  assign res.payload_valid = pv;
  assign res.done_res      = vd;
  assign res.status        = vst;
  assign res.ret_value     = vval;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import hrsp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic       has;
    logic [1:0] st;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  http_response_stream_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Parser state as the byte stream is consumed.
  logic [1:0]  ph;
  logic [1:0]  n_spaces;
  logic [2:0]  code_pos;
  logic [4:0]  hdr_pos;
  logic        blank_line;
  logic        cr_seen;
  logic [31:0] clen;
  logic        clen_known;
  logic        clen_neg;
  logic [31:0] body_n;
  logic [63:0] ret_acc;
  logic        decided;
  logic        fits;
  logic [2:0]  num_state;
  logic [15:0] payload_limit;

  string code_ref = "200";
  string cl_ref = "content-length: ";

  out_item_t step_res;
  logic      step_has;
  out_item_t pending_out[$];
  in_item_t  resp_bytes[$];
  stim_row_t directed_rows [0:23];

  int snd_idle;
  int rcv_idle;
  int mism;
  int n_bytes;
  int n_resp;
  int n_payload;
  int n_results;
  int status_seen [4];

  task automatic restart_parse();
    ph = PH_STATUS;
    n_spaces = 2'd0;
    code_pos = 3'd0;
    hdr_pos = 5'd0;
    blank_line = 1'b1;
    cr_seen = 1'b0;
    clen = 32'd0;
    clen_known = 1'b0;
    clen_neg = 1'b0;
    body_n = 32'd0;
    ret_acc = 64'd0;
    decided = 1'b0;
    fits = 1'b0;
    num_state = VS_START;
  endtask

  task automatic give_verdict(input logic [1:0] st, input logic [63:0] v);
    step_res.done_res = 1'b1;
    step_res.status = st;
    step_res.ret_value = v;
    decided = 1'b1;
    ph = PH_DONE;
  endtask

  task automatic take_digit(input logic [7:0] b);
    logic [63:0] lim;
    logic [63:0] nv;
    lim = clen_neg ? 64'd2147483648 : 64'd2147483647;
    nv = {32'd0, clen} * 64'd10 + {56'd0, b - CH_0};
    if (nv > lim) begin
      num_state = VS_ERR;
    end else begin
      clen = nv[31:0];
    end
  endtask

  task automatic length_char(input logic [7:0] b);
    logic dig;
    dig = (b >= CH_0) && (b <= CH_9);
    case (num_state)
      VS_START: begin
        if (b == CH_PLUS) begin
          num_state = VS_SIGN;
        end else if (b == CH_MINUS) begin
          clen_neg = 1'b1;
          num_state = VS_SIGN;
        end else if (dig) begin
          num_state = VS_DIGITS;
          take_digit(b);
        end else begin
          num_state = VS_ERR;
        end
      end
      VS_SIGN: begin
        if (dig) begin
          num_state = VS_DIGITS;
          take_digit(b);
        end else begin
          num_state = VS_ERR;
        end
      end
      VS_DIGITS: begin
        if (dig) begin
          take_digit(b);
        end else if (b == CH_LF) begin
          num_state = VS_LF;
        end else begin
          num_state = VS_ERR;
        end
      end
      default: num_state = VS_ERR;
    endcase
  endtask

  task automatic status_char(input logic [7:0] b);
    if (b == CH_NUL) begin
      give_verdict(ST_BAD, 64'd0);
    end else if (b == CH_CR) begin
      if (n_spaces == 2'd0) begin
        give_verdict(ST_BAD, 64'd0);
      end else if (code_pos == CODE_LEN) begin
        ph = PH_HEADER;
        cr_seen = 1'b1;
        blank_line = 1'b1;
        hdr_pos = 5'd0;
      end else begin
        give_verdict(ST_NOT200, 64'd0);
      end
    end else if (b == CH_SP) begin
      if (n_spaces < SPACE_MAX) n_spaces = n_spaces + 2'd1;
    end else if (n_spaces == 2'd1) begin
      if (code_pos < CODE_LEN && b == code_ref[code_pos]) begin
        code_pos = code_pos + 3'd1;
      end else begin
        code_pos = CODE_BAD;
      end
    end
  endtask

  task automatic header_char(input logic [7:0] b);
    logic [7:0] lc;
    if (b == CH_NUL) begin
      give_verdict(ST_BAD, 64'd0);
    end else if (b == CH_CR) begin
      if (blank_line) begin
        if (!clen_known || clen_neg || clen < VALUE_BYTES) begin
          give_verdict(ST_BAD, 64'd0);
        end else begin
          ph = PH_BODY;
          body_n = 32'd0;
          ret_acc = 64'd0;
          fits = (clen - VALUE_BYTES) <= {16'd0, payload_limit};
          cr_seen = 1'b1;
        end
      end else if (hdr_pos == HDR_MATCHED && num_state != VS_DIGITS
                   && num_state != VS_LF) begin
        give_verdict(ST_BAD, 64'd0);
      end else begin
        if (hdr_pos == HDR_MATCHED) clen_known = 1'b1;
        blank_line = 1'b1;
        hdr_pos = 5'd0;
        cr_seen = 1'b1;
      end
    end else begin
      blank_line = 1'b0;
      if (hdr_pos < HDR_MATCHED) begin
        lc = (b >= CH_UA && b <= CH_UZ) ? b + CASE_OFS : b;
        if (lc == cl_ref[hdr_pos]) begin
          hdr_pos = hdr_pos + 5'd1;
          if (hdr_pos == HDR_MATCHED) begin
            clen = 32'd0;
            clen_neg = 1'b0;
            num_state = VS_START;
          end
        end else begin
          hdr_pos = HDR_MISMATCH;
        end
      end else if (hdr_pos == HDR_MATCHED) begin
        length_char(b);
      end
    end
  endtask

  task automatic parse_byte(input in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    step_res = '0;
    if (ph != PH_DONE) begin
      if (cr_seen && b == CH_LF) begin
        cr_seen = 1'b0;
      end else begin
        cr_seen = 1'b0;
        case (ph)
          PH_STATUS: status_char(b);
          PH_HEADER: header_char(b);
          default: begin
            if (body_n < VALUE_BYTES) begin
              ret_acc = ret_acc | ({56'd0, b} << (body_n * 8));
            end else if (fits) begin
              step_res.payload_valid = 1'b1;
              step_res.payload_byte = b;
            end
            body_n = body_n + 32'd1;
            if (body_n >= clen) begin
              if (fits) begin
                give_verdict(ST_OK, ret_acc);
              end else begin
                give_verdict(ST_NOSPACE, 64'd0);
              end
            end
          end
        endcase
      end
    end
    if (it.rx_last) begin
      if (!decided) give_verdict(ST_BAD, 64'd0);
      restart_parse();
    end
    step_has = step_res.payload_valid || step_res.done_res;
  endtask

  function automatic string show(input out_item_t r);
    return $sformatf("byte=%h pv=%b done=%b status=%0d value=%h",
                     r.payload_byte, r.payload_valid, r.done_res, r.status, r.ret_value);
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_out.size() == 0) begin
      mism++;
      if (mism <= 10) $display("unexpected transaction: %s", show(got));
    end else begin
      want = pending_out.pop_front();
      if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid
          || got.done_res !== want.done_res || got.status !== want.status
          || got.ret_value !== want.ret_value) begin
        mism++;
        if (mism <= 10) begin
          $display("transaction %0d: expected %s", n_results, show(want));
          $display("transaction %0d: actual   %s", n_results, show(got));
        end
      end
    end
    n_results++;
    if (got.payload_valid === 1'b1) n_payload++;
    if (got.done_res === 1'b1) status_seen[got.status]++;
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    payload_limit = v;
  endtask

  task automatic add_byte(input logic [7:0] b);
    in_item_t t;
    t.rx_byte = b;
    t.rx_last = 1'b0;
    resp_bytes.push_back(t);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic end_line();
    add_byte(CH_CR);
    if ($urandom_range(4) != 0) add_byte(CH_LF);
  endtask

  task automatic add_length(input string v);
    int i;
    logic [7:0] c;
    for (i = 0; i < cl_ref.len(); i++) begin
      c = cl_ref[i];
      if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - CASE_OFS;
      add_byte(c);
    end
    add_text(v);
  endtask

  task automatic build_response();
    string code;
    string val;
    int len_v;
    int data_len;
    int keep;
    int i;
    in_item_t t;
    resp_bytes.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(30, 1)) add_byte(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(9))
        0: code = "2000";
        1: code = "20";
        2: code = "201";
        3: code = "";
        default: code = "200";
      endcase
      if ($urandom_range(19) == 0) begin
        add_text("HTTP/1.1");
      end else begin
        add_text({"HTTP/1.1 ", code, " OK"});
      end
      end_line();
      repeat ($urandom_range(2)) begin
        case ($urandom_range(3))
          0: add_text("Content-Type: text/plain");
          1: add_text("content-lengt: 99");
          2: add_text("Content-Length; 5");
          default: begin
            repeat ($urandom_range(12, 1)) begin
              add_byte($urandom_range(29) == 0 ? CH_NUL : 8'($urandom_range(126, 32)));
            end
          end
        endcase
        end_line();
      end
      if ($urandom_range(7) == 0) begin
        add_length({"+", $sformatf("%0d", $urandom_range(99))});
        end_line();
      end
      len_v = 8 + $urandom_range(20);
      data_len = len_v;
      if ($urandom_range(5) != 0) begin
        val = $sformatf("%0d", len_v);
        if ($urandom_range(6) == 0) val = {"+", val};
        if ($urandom_range(9) == 0) val = {val, "\n"};
      end else begin
        case ($urandom_range(13))
          0: val = "";
          1: val = "-";
          2: val = "+";
          3: val = "12x";
          4: val = "-12";
          5: val = "2147483647";
          6: val = "2147483648";
          7: val = "-2147483648";
          8: val = "-2147483649";
          9: val = "-0";
          10: val = "7";
          11: val = "0";
          12: val = "000000000009";
          default: val = "1\n\n";
        endcase
        data_len = $urandom_range(30);
      end
      if ($urandom_range(9) != 0) begin
        add_length(val);
        end_line();
      end
      end_line();
      repeat (data_len) add_byte(8'($urandom_range(255)));
      repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        keep = $urandom_range(resp_bytes.size(), 1);
        while (resp_bytes.size() > keep) void'(resp_bytes.pop_back());
      end
    end
    i = resp_bytes.size() - 1;
    t = resp_bytes[i];
    t.rx_last = 1'b1;
    resp_bytes[i] = t;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  initial begin
    #2000000;
    $display("http_response_stream_parser: mismatch");
    $finish;
  end

  initial begin
    int seg;
    int target;
    int i;
    in_item_t it;
    stim_row_t row;
    out_item_t r;
    logic [15:0] limit_v;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 16'd0;
    snd_idle = 31;
    rcv_idle = 67;
    mism = 0;
    n_bytes = 0;
    n_resp = 0;
    n_payload = 0;
    n_results = 0;
    for (i = 0; i < 4; i++) status_seen[i] = 0;
    payload_limit = MAX_PAYLOAD_RESET;
    restart_parse();

    directed_rows = '{
      '{CH_NUL, 1'b0, 1'b1, 1'b1, ST_BAD},
      '{"X",    1'b1, 1'b1, 1'b0, ST_OK},
      '{"H",    1'b1, 1'b1, 1'b1, ST_BAD},
      '{"A",    1'b0, 1'b1, 1'b0, ST_OK},
      '{CH_CR,  1'b0, 1'b1, 1'b1, ST_BAD},
      '{8'hFF,  1'b1, 1'b1, 1'b0, ST_OK},
      '{CH_SP,  1'b0, 1'b0, 1'b0, ST_OK},
      '{"2",    1'b0, 1'b0, 1'b0, ST_OK},
      '{"0",    1'b0, 1'b0, 1'b0, ST_OK},
      '{"1",    1'b0, 1'b0, 1'b0, ST_OK},
      '{CH_CR,  1'b0, 1'b1, 1'b1, ST_NOT200},
      '{8'h80,  1'b1, 1'b1, 1'b0, ST_OK},
      '{CH_SP,  1'b0, 1'b0, 1'b0, ST_OK},
      '{CH_SP,  1'b0, 1'b0, 1'b0, ST_OK},
      '{CH_CR,  1'b0, 1'b1, 1'b1, ST_NOT200},
      '{8'h7F,  1'b1, 1'b1, 1'b0, ST_OK},
      '{CH_SP,  1'b0, 1'b0, 1'b0, ST_OK},
      '{"2",    1'b0, 1'b0, 1'b0, ST_OK},
      '{"0",    1'b0, 1'b0, 1'b0, ST_OK},
      '{"0",    1'b0, 1'b0, 1'b0, ST_OK},
      '{CH_CR,  1'b0, 1'b1, 1'b0, ST_OK},
      '{CH_LF,  1'b0, 1'b1, 1'b0, ST_OK},
      '{CH_NUL, 1'b0, 1'b1, 1'b1, ST_BAD},
      '{8'h55,  1'b1, 1'b1, 1'b0, ST_OK}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 24; i++) begin
      row = directed_rows[i];
      it.rx_byte = row.data;
      it.rx_last = row.last;
      send_item(it);
      parse_byte(it);
      if (row.typed) begin
        if (row.has) begin
          r = '0;
          r.done_res = 1'b1;
          r.status = row.st;
          pending_out.push_back(r);
        end
      end else if (step_has) begin
        pending_out.push_back(step_res);
      end
    end

    for (seg = 0; seg < 6; seg++) begin
      drain();
      case (seg / 2)
        0: begin
          snd_idle = 31;
          rcv_idle = 67;
        end
        1: begin
          snd_idle = 67;
          rcv_idle = 31;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      case (seg)
        0: limit_v = 16'd0;
        1: limit_v = 16'hFFFF;
        2: limit_v = 16'($urandom_range(20, 1));
        3: limit_v = 16'($urandom_range(24));
        4: limit_v = 16'd12;
        default: limit_v = MAX_PAYLOAD_RESET;
      endcase
      write_limit(limit_v);
      target = n_bytes + 333;
      while (n_bytes < target) begin
        build_response();
        n_resp++;
        for (i = 0; i < resp_bytes.size(); i++) begin
          send_item(resp_bytes[i]);
          parse_byte(resp_bytes[i]);
          if (step_has) pending_out.push_back(step_res);
        end
      end
    end

    drain();
    mism = mism + pending_out.size();
    $display("Sent %0d bytes (%0d random responses) under six payload limits%s",
             n_bytes, n_resp, " including 0 and 65535.");
    $display("Checked %0d transactions: %0d payload bytes, verdicts %s %0d/%0d/%0d/%0d.",
             n_results, n_payload, "ok/bad/not200/too large", status_seen[ST_OK],
             status_seen[ST_BAD], status_seen[ST_NOT200], status_seen[ST_NOSPACE]);
    if (mism == 0) begin
      $display("http_response_stream_parser: match");
    end else begin
      $display("%0d mismatches", mism);
      $display("http_response_stream_parser: mismatch");
    end
    $finish;
  end

endmodule
